@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, off during reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication form: once cond holds, prop must hold in the same cycle
`define ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

@@ rtl/mi3_pkg.sv @@
`timescale 1ns / 1ps
package mi3_pkg;

   localparam int MAT_N = 9;
   // determinant width at the smallest fraction width (65 - 8)
   localparam int DET_W = 57;

   typedef struct packed {
      logic                    singular;
      logic signed [DET_W-1:0] det;
      logic [MAT_N-1:0][31:0]  cof;
      logic [MAT_N-1:0][31:0]  mat;
   } item_type;

endpackage

@@ rtl/mi3_front.sv @@
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [MAT_N-1:0][31:0] in_mat,
   input  logic [16:0]            eps,
   output logic                   out_valid,
   output item_type               out_item
);

   localparam int SUM_W = 65;
   localparam int DW    = SUM_W - FRAC_BITS;
   localparam int MW    = DW - 1;

   logic [4:0] v_ff;
   logic [MAT_N-1:0][31:0] mat_ff [5];

   logic signed [63:0] pa_ff [MAT_N];
   logic signed [63:0] pb_ff [MAT_N];
   logic signed [63:0] pa_in [MAT_N];
   logic signed [63:0] pb_in [MAT_N];
   logic signed [63:0] minor_ff [MAT_N];
   logic signed [63:0] minor_in [MAT_N];
   logic signed [31:0] cof_ff [MAT_N];
   logic signed [31:0] cof_in [MAT_N];
   logic [MAT_N-1:0][31:0] cofd_ff;
   logic [MAT_N-1:0][31:0] cofe_ff;
   logic signed [63:0] dp_ff [3];
   logic signed [63:0] dp_in [3];
   logic signed [SUM_W-1:0] sum_in;
   logic signed [DW-1:0] det_ff;
   logic signed [DW-1:0] det_in;
   logic [MW-1:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   genvar k;
   generate
      for (k = 0; k < MAT_N; k++) begin : g_cof
         localparam int R  = k / 3;
         localparam int C  = k % 3;
         localparam int R1 = (R == 0) ? 1 : 0;
         localparam int R2 = (R == 2) ? 1 : 2;
         localparam int C1 = (C == 0) ? 1 : 0;
         localparam int C2 = (C == 2) ? 1 : 2;
         logic signed [63:0] sh;

         assign pa_in[k] = $signed(in_mat[R1*3+C1]) * $signed(in_mat[R2*3+C2]);
         assign pb_in[k] = $signed(in_mat[R1*3+C2]) * $signed(in_mat[R2*3+C1]);
         // odd positions take the negated minor
         assign minor_in[k] = ((R + C) % 2 == 1) ? pb_ff[k] - pa_ff[k]
                                                 : pa_ff[k] - pb_ff[k];
         assign sh = minor_ff[k] >>> FRAC_BITS;
         assign cof_in[k] = (sh > 64'sd2147483647)  ? 32'sh7fffffff :
                            (sh < -64'sd2147483648) ? 32'sh80000000 : sh[31:0];

         always_ff @(posedge clock) begin
            pa_ff[k]    <= pa_in[k];
            pb_ff[k]    <= pb_in[k];
            minor_ff[k] <= minor_in[k];
            cof_ff[k]   <= cof_in[k];
         end
      end

      for (k = 0; k < 3; k++) begin : g_dp
         assign dp_in[k] = $signed(mat_ff[2][k]) * cof_ff[k];
         always_ff @(posedge clock) begin
            dp_ff[k] <= dp_in[k];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAT_N; i++) begin
         cofd_ff[i] <= cof_ff[i];
      end
      cofe_ff <= cofd_ff;
   end

   assign sum_in = SUM_W'(dp_ff[0]) + SUM_W'(dp_ff[1]) + SUM_W'(dp_ff[2]);
   assign det_in = DW'(sum_in >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      mat_ff[0] <= in_mat;
      mat_ff[1] <= mat_ff[0];
      mat_ff[2] <= mat_ff[1];
      mat_ff[3] <= mat_ff[2];
      mat_ff[4] <= mat_ff[3];
      det_ff    <= det_in;
   end

   // |det| always fits one bit less than det itself
   always_comb begin
      if (det_ff < 0) begin
         mag = MW'(-det_ff);
      end else begin
         mag = MW'(det_ff);
      end
   end

   assign out_valid         = v_ff[4];
   assign out_item.singular = (mag <= MW'(eps));
   assign out_item.det      = DET_W'(det_ff);
   assign out_item.cof      = cofe_ff;
   assign out_item.mat      = mat_ff[4];

endmodule

@@ rtl/mi3_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mi3_queue import mi3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head,
   output logic     full,
   output logic     empty
);

   item_type mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_IMPL(a_no_overflow, push, !full || pop, "request pushed into full queue")
   `ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")
   `ASSERT_CLK(a_cnt_range, cnt_ff <= 2'd2, "queue count out of range")

endmodule

@@ rtl/mi3_back.sv @@
`timescale 1ns / 1ps
module mi3_back import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  item_type               in_item,
   output logic                   out_valid,
   output logic [MAT_N-1:0][31:0] out_mat,
   output logic                   out_singular
);

   localparam int DW = 65 - FRAC_BITS;
   localparam int MW = DW - 1;
   localparam int QW = 32 + FRAC_BITS;

   logic [QW:0] sv_ff;
   logic [QW:0] sing_ff;
   logic [MW-1:0] d_ff [QW+1];
   logic [MAT_N-1:0] neg_ff [QW+1];
   logic [MAT_N-1:0] neg_in;
   logic [MAT_N-1:0][31:0] echo_ff [QW+1];
   logic [MW-1:0] rem_ff [QW+1][MAT_N];
   logic [QW-1:0] nq_ff [QW+1][MAT_N];

   logic signed [DW-1:0] det_in;
   logic [MW-1:0] d_in;

   logic out_valid_ff;
   logic out_sing_ff;
   logic [MAT_N-1:0][31:0] out_mat_ff;
   logic [MAT_N-1:0][31:0] out_mat_in;

   assign det_in = DW'(in_item.det);
   assign d_in   = (det_in < 0) ? MW'(-det_in) : MW'(det_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sv_ff        <= {sv_ff[QW-1:0], in_valid};
         out_valid_ff <= sv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      d_ff[0]    <= d_in;
      sing_ff    <= {sing_ff[QW-1:0], in_item.singular};
      neg_ff[0]  <= neg_in;
      echo_ff[0] <= in_item.mat;
   end

   genvar k, s;
   generate
      for (k = 0; k < MAT_N; k++) begin : g_load
         localparam int I = k / 3;
         localparam int J = k % 3;
         logic signed [31:0] cof;
         logic [31:0] cmag;

         // lane (i,j) divides the transposed cofactor
         assign cof  = $signed(in_item.cof[J*3+I]);
         assign cmag = (cof < 0) ? 32'(-33'(cof)) : 32'(cof);
         assign neg_in[k] = cof[31] ^ det_in[DW-1];

         always_ff @(posedge clock) begin
            rem_ff[0][k] <= '0;
            nq_ff[0][k]  <= QW'(cmag) << FRAC_BITS;
         end
      end

      // one quotient bit per stage, restoring
      for (s = 0; s < QW; s++) begin : g_stage
         always_ff @(posedge clock) begin
            d_ff[s+1]    <= d_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            echo_ff[s+1] <= echo_ff[s];
         end
         for (k = 0; k < MAT_N; k++) begin : g_lane
            logic [MW:0] t;
            logic [MW:0] diff;
            logic ge;
            assign t    = {rem_ff[s][k], nq_ff[s][k][QW-1]};
            assign diff = t - {1'b0, d_ff[s]};
            assign ge   = (t >= {1'b0, d_ff[s]});
            always_ff @(posedge clock) begin
               rem_ff[s+1][k] <= ge ? diff[MW-1:0] : t[MW-1:0];
               nq_ff[s+1][k]  <= {nq_ff[s][k][QW-2:0], ge};
            end
         end
      end

      for (k = 0; k < MAT_N; k++) begin : g_out
         logic [QW-1:0] q;
         logic [QW-1:0] qn;
         logic [31:0] res;
         assign q  = nq_ff[QW][k];
         assign qn = QW'(0) - q;
         always_comb begin
            if (neg_ff[QW][k]) begin
               res = (q > QW'(32'h80000000)) ? 32'h80000000 : qn[31:0];
            end else begin
               res = (q > QW'(32'h7fffffff)) ? 32'h7fffffff : q[31:0];
            end
         end
         assign out_mat_in[k] = sing_ff[QW] ? echo_ff[QW][k] : res;
      end
   endgenerate

   always_ff @(posedge clock) begin
      out_mat_ff  <= out_mat_in;
      out_sing_ff <= sing_ff[QW];
   end

   assign out_valid    = out_valid_ff;
   assign out_mat      = out_mat_ff;
   assign out_singular = out_sing_ff;

endmodule

@@ rtl/matrix_inverse_3x3_core.sv @@
// Throughput: one matrix per cycle; busy stays low since the divider never stalls.
// The restoring divider yields one quotient bit per stage, in 32 + FRAC_BITS stages.
// Reset (synchronous, active high) empties the pipeline and queue and sets det_epsilon to 1.
`timescale 1ns / 1ps
module matrix_inverse_3x3_core import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_a00,
   input  logic [31:0] req_a01,
   input  logic [31:0] req_a02,
   input  logic [31:0] req_a10,
   input  logic [31:0] req_a11,
   input  logic [31:0] req_a12,
   input  logic [31:0] req_a20,
   input  logic [31:0] req_a21,
   input  logic [31:0] req_a22,
   output logic        rsp_strobe,
   output logic [31:0] rsp_r00,
   output logic [31:0] rsp_r01,
   output logic [31:0] rsp_r02,
   output logic [31:0] rsp_r10,
   output logic [31:0] rsp_r11,
   output logic [31:0] rsp_r12,
   output logic [31:0] rsp_r20,
   output logic [31:0] rsp_r21,
   output logic [31:0] rsp_r22,
   output logic        rsp_singular,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_det_epsilon
);

   logic [16:0] eps_ff;
   logic [MAT_N-1:0][31:0] req_mat;
   logic [MAT_N-1:0][31:0] rsp_mat;
   logic accept;
   logic f_valid;
   item_type f_item;
   item_type q_head;
   logic q_full;
   logic q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 17'd1;
      end else if (csr_valid) begin
         eps_ff <= csr_det_epsilon;
      end
   end

   assign busy   = q_full;
   assign accept = start && !busy;

   assign req_mat = {req_a22, req_a21, req_a20, req_a12, req_a11, req_a10,
                     req_a02, req_a01, req_a00};

   mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_mat   (req_mat),
      .eps      (eps_ff),
      .out_valid(f_valid),
      .out_item (f_item)
   );

   mi3_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_item(f_item),
      .pop      (!q_empty),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (!q_empty),
      .in_item     (q_head),
      .out_valid   (rsp_strobe),
      .out_mat     (rsp_mat),
      .out_singular(rsp_singular)
   );

   assign rsp_r00 = rsp_mat[0];
   assign rsp_r01 = rsp_mat[1];
   assign rsp_r02 = rsp_mat[2];
   assign rsp_r10 = rsp_mat[3];
   assign rsp_r11 = rsp_mat[4];
   assign rsp_r12 = rsp_mat[5];
   assign rsp_r20 = rsp_mat[6];
   assign rsp_r21 = rsp_mat[7];
   assign rsp_r22 = rsp_mat[8];

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb import mi3_pkg::*;;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 40;
   localparam int STALL_LIMIT = 5000;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;
   localparam logic [31:0] S32_MAX = 32'h7fff_ffff;

   typedef logic [31:0] mat9_type [MAT_N];
   typedef struct {
      mat9_type r;
      logic     singular;
   } inv_result_type;
   typedef enum logic {OP_MATRIX, OP_EPSILON} op_type;
   typedef struct {
      op_type      op;
      mat9_type    m;
      logic [16:0] eps;
   } request_type;

   logic clock, reset;
   logic start, busy;
   logic [31:0] req_a [MAT_N];
   logic rsp_strobe, rsp_singular;
   logic [31:0] rsp_r [MAT_N];
   logic csr_valid, csr_ready;
   logic [16:0] csr_det_epsilon;

   request_type    pending [$];
   inv_result_type inverses_due [$];
   logic [16:0]    eps_model;
   int             errors = 0;
   int             gap, calm, stall_cycles;

   matrix_inverse_3x3_core #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a00(req_a[0]), .req_a01(req_a[1]), .req_a02(req_a[2]),
      .req_a10(req_a[3]), .req_a11(req_a[4]), .req_a12(req_a[5]),
      .req_a20(req_a[6]), .req_a21(req_a[7]), .req_a22(req_a[8]),
      .rsp_strobe(rsp_strobe),
      .rsp_r00(rsp_r[0]), .rsp_r01(rsp_r[1]), .rsp_r02(rsp_r[2]),
      .rsp_r10(rsp_r[3]), .rsp_r11(rsp_r[4]), .rsp_r12(rsp_r[5]),
      .rsp_r20(rsp_r[6]), .rsp_r21(rsp_r[7]), .rsp_r22(rsp_r[8]),
      .rsp_singular(rsp_singular),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_det_epsilon(csr_det_epsilon)
   );

   function automatic logic signed [95:0] sat32(logic signed [95:0] v);
      if (v > 96'sd2147483647) return 96'sd2147483647;
      if (v < -96'sd2147483648) return -96'sd2147483648;
      return v;
   endfunction

   // adjugate inverse with floored cofactors and truncated quotients
   function automatic inv_result_type invert_3x3(mat9_type m, logic [16:0] eps);
      longint a [3][3];
      logic signed [95:0] cof [3][3];
      logic signed [95:0] minor, acc, det, mag, epsw, num;
      int r1, r2, c1, c2;
      inv_result_type res;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            a[r][c] = longint'(signed'(m[r*3+c]));
      for (int r = 0; r < 3; r++) begin
         r1 = (r == 0) ? 1 : 0;
         r2 = (r == 2) ? 1 : 2;
         for (int c = 0; c < 3; c++) begin
            c1 = (c == 0) ? 1 : 0;
            c2 = (c == 2) ? 1 : 2;
            minor = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
            if ((r + c) % 2 == 1) minor = -minor;
            cof[r][c] = sat32(minor >>> FRAC);
         end
      end
      acc = 0;
      for (int c = 0; c < 3; c++) begin
         minor = a[0][c];
         acc = acc + minor * cof[0][c];
      end
      det = acc >>> FRAC;
      mag = (det < 0) ? -det : det;
      epsw = {79'd0, eps};
      if (mag <= epsw) begin
         res.r = m;
         res.singular = 1'b1;
      end else begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               num = cof[c][r] <<< FRAC;
               res.r[r*3+c] = 32'(sat32(num / det));
            end
         res.singular = 1'b0;
      end
      return res;
   endfunction

   function automatic mat9_type diag(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      mat9_type m;
      m = '{default: 32'd0};
      m[0] = x;
      m[4] = y;
      m[8] = z;
      return m;
   endfunction

   // signed value within +/- span (in Q16.16 units of LSB)
   function automatic logic [31:0] near_zero(int unsigned span);
      return 32'($urandom_range(0, 2 * span)) - 32'(span);
   endfunction

   function automatic mat9_type random_matrix();
      mat9_type m;
      int unsigned kind, k;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < MAT_N; i++) m[i] = near_zero(32'h8_0000);
      case (kind)
         0, 1: begin
            for (int i = 0; i < MAT_N; i++) m[i] = $urandom;
         end
         6, 7: begin
            // nearly rank deficient: row 2 tracks rows 0 and 1
            k = $urandom_range(0, 3);
            for (int c = 0; c < 3; c++)
               m[6+c] = m[c] * k - m[3+c] + near_zero($urandom_range(0, 4));
         end
         8: begin
            for (int i = 0; i < MAT_N; i++)
               if ($urandom_range(0, 1)) m[i] = $urandom;
         end
         9: begin
            for (int i = 0; i < MAT_N; i++) m[i] = near_zero(32'h100);
         end
         default: ;
      endcase
      return m;
   endfunction

   task automatic push_mat(mat9_type m);
      request_type q;
      q.op = OP_MATRIX;
      q.m = m;
      q.eps = '0;
      pending.push_back(q);
   endtask

   task automatic push_eps(logic [16:0] e);
      request_type q;
      q.op = OP_EPSILON;
      q.m = '{default: 32'd0};
      q.eps = e;
      pending.push_back(q);
   endtask

   task automatic push_random(int n);
      for (int i = 0; i < n; i++) push_mat(random_matrix());
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      mat9_type m;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, epsilon at its reset value
      push_mat(diag(ONE, ONE, ONE));
      push_mat(diag(2 * ONE, 3 * ONE, 4 * ONE));
      push_mat(diag(0, 0, 0));
      push_mat('{default: S32_MIN});
      push_mat('{default: S32_MAX});
      push_mat('{S32_MIN, S32_MAX, 0, S32_MAX, S32_MIN, 1, 0, 1, S32_MIN});
      push_mat(diag(S32_MAX, S32_MAX, S32_MAX));
      push_mat(diag(S32_MIN, S32_MAX, S32_MIN));
      push_mat(diag(1, 1, 1));
      push_mat(diag(32'h100, 32'h100, 32'h100));
      push_mat(diag(ONE, ONE, 1));
      push_mat(diag(ONE, ONE, 2));
      push_mat(diag(ONE, ONE, -32'sd1));
      push_mat(diag(ONE, ONE, -32'sd2));
      push_mat('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});
      push_mat('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE,
                 9 * ONE});
      push_mat('{32'h0000_b505, -32'sh0000_b505, 0, 32'h0000_b505, 32'h0000_b505, 0,
                 0, 0, ONE});

      push_eps(17'd0);
      push_mat(diag(0, 0, 0));
      push_mat(diag(ONE, ONE, 1));
      push_mat(diag(ONE, ONE, -32'sd1));
      push_random(280);

      push_eps(17'd65536);
      push_mat(diag(ONE, ONE, ONE));
      push_mat(diag(ONE, ONE, ONE + 1));
      push_mat(diag(ONE, ONE, -32'sd65536));
      push_random(280);

      push_eps(17'h1_ffff);
      push_random(40);
      push_eps(17'($urandom_range(2, 65535)));
      push_random(280);

      while (pending.size() != 0 || inverses_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (errors == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

   // driver: matrices and epsilon writes in queue order
   always @(posedge clock) begin
      logic took, next_start, next_csr;
      took = 1'b0;
      next_start = 1'b0;
      next_csr = 1'b0;
      if (reset) begin
         eps_model = 17'd1;
         gap = 0;
         calm = 0;
      end else begin
         if (start && !busy) begin
            inverses_due.push_back(invert_3x3(req_a, eps_model));
            void'(pending.pop_front());
            took = 1'b1;
         end else if (csr_valid && csr_ready) begin
            eps_model = csr_det_epsilon;
            void'(pending.pop_front());
            took = 1'b1;
         end
         if (took) begin
            if (calm > 0) begin
               calm--;
               gap = 0;
            end else begin
               case ($urandom_range(0, 19))
                  0: calm = $urandom_range(20, 60);
                  1, 2: gap = $urandom_range(10, 60);
                  3, 4, 5, 6, 7, 8: gap = $urandom_range(1, 3);
                  default: gap = 0;
               endcase
            end
         end
         if (gap > 0) begin
            gap--;
         end else if (pending.size() != 0) begin
            if (pending[0].op == OP_MATRIX) begin
               req_a <= pending[0].m;
               next_start = 1'b1;
            end else begin
               // write epsilon only once the pipeline has drained
               csr_det_epsilon <= pending[0].eps;
               next_csr = (inverses_due.size() == 0);
            end
         end
      end
      start <= next_start;
      csr_valid <= next_csr;
   end

   initial begin
      start = 1'b0;
      csr_valid = 1'b0;
      csr_det_epsilon = '0;
      req_a = '{default: 32'd0};
   end

   // monitor and watchdog
   always @(posedge clock) begin
      inv_result_type want;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_strobe) begin
            if (inverses_due.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               want = inverses_due.pop_front();
               for (int i = 0; i < MAT_N; i++)
                  if (rsp_r[i] !== want.r[i]) begin
                     $error("r%0d%0d: expected %h, got %h", i / 3, i % 3, want.r[i],
                            rsp_r[i]);
                     errors++;
                  end
               if (rsp_singular !== want.singular) begin
                  $error("singular: expected %b, got %b", want.singular, rsp_singular);
                  errors++;
               end
            end
         end
         if (rsp_strobe || (start && !busy) || (csr_valid && csr_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_queue.sv
rtl/mi3_back.sv
rtl/matrix_inverse_3x3_core.sv
bench/tb.sv
